// ===== src/lslf_pkg.sv =====
// Shared widths, step codes and controller/datapath command and status types
// for the least-squares line fit block. No dependencies.
package lslf_pkg;

  localparam int X_W             = 11;   // point_index width
  localparam int Y_IN_W          = 16;   // sample_value port width
  localparam int N_OUT_W         = 11;   // points_used width
  localparam int Q_W             = 32;   // Q16.16 result width
  localparam int FRAC_W          = 16;   // fraction bits of the results
  localparam int DET_W           = 64;   // determinant arithmetic width (mod 2^64)
  localparam int DIGIT_W         = 8;    // multiplier digit per cycle
  localparam int MAX_POINTS_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Products of the solve, in the order they are formed
  typedef enum logic [2:0] {
    MS_SXX_N  = 3'd0,   // Sxx * n
    MS_SX_SX  = 3'd1,   // Sx * Sx    -> D
    MS_SXY_N  = 3'd2,   // Sxy * n
    MS_SY_SX  = 3'd3,   // Sy * Sx    -> A
    MS_SXX_SY = 3'd4,   // Sxx * Sy
    MS_SX_SXY = 3'd5,   // Sxy * Sx   -> B
    MS_A_N    = 3'd6    // A * n      -> A*n + B, A + B
  } mstep_t;

  // Divisions of the solve
  typedef enum logic [1:0] {
    DS_SLOPE     = 2'd0,
    DS_INTERCEPT = 2'd1,
    DS_FIRST     = 2'd2,
    DS_COUNT     = 2'd3
  } dstep_t;

  typedef struct packed {
    logic   capture;   // latch the incoming item
    logic   accum;     // add the latched point to the sums
    logic   mul_go;
    logic   div_go;
    logic   emit;      // present the result, clear the sums
    mstep_t mstep;
    dstep_t dstep;
  } cmd_t;

  typedef struct packed {
    logic final_pt;
    logic det_zero;
    logic mul_done;
    logic div_done;
  } stat_t;

endpackage

// ===== src/lslf_mul.sv =====
// Digit-serial 64-bit multiplier, one 8-bit digit of b per cycle, result mod 2^64.
// b is two's complement; its top digit is taken as signed. Depends on lslf_pkg.
module lslf_mul #(
  parameter int ND = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              go,
  input  logic [lslf_pkg::DET_W-1:0]        a,
  input  logic [ND*lslf_pkg::DIGIT_W-1:0]   b,
  output logic [lslf_pkg::DET_W-1:0]        prod,
  output logic                              done
);

  localparam int OP_W = ND * lslf_pkg::DIGIT_W;
  localparam int CW   = $clog2(ND + 1);
  localparam int PP_W = lslf_pkg::DET_W + lslf_pkg::DIGIT_W + 1;

  logic                              run;
  logic [CW-1:0]                     cnt;
  logic [lslf_pkg::DET_W-1:0]        a_sh;
  logic [OP_W-1:0]                   b_sh;
  logic [lslf_pkg::DET_W-1:0]        acc;
  logic                              last;
  logic signed [lslf_pkg::DIGIT_W:0] digit;
  logic signed [PP_W-1:0]            pp_full;

  assign last    = (cnt == CW'(ND - 1));
  assign digit   = $signed({last & b_sh[lslf_pkg::DIGIT_W-1], b_sh[lslf_pkg::DIGIT_W-1:0]});
  assign pp_full = $signed(a_sh) * digit;
  assign prod    = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + CW'(1);
        if (last) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc  <= '0;
      a_sh <= a;
      b_sh <= b;
    end else if (run) begin
      acc  <= acc + pp_full[lslf_pkg::DET_W-1:0];
      a_sh <= a_sh << lslf_pkg::DIGIT_W;
      b_sh <= b_sh >> lslf_pkg::DIGIT_W;
    end
  end

endmodule

// ===== src/lslf_div.sv =====
// Restoring divider: round(num * 2^16 / den) to nearest, halves away from zero,
// saturated to 32 bits signed. One quotient bit per cycle. Depends on lslf_pkg.
module lslf_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [lslf_pkg::DET_W-1:0] num,
  input  logic [lslf_pkg::DET_W-1:0] den,
  output logic [lslf_pkg::Q_W-1:0]   quo,
  output logic                       done
);

  localparam int DW = lslf_pkg::DET_W;
  localparam int QW = lslf_pkg::Q_W;
  localparam int FW = lslf_pkg::FRAC_W;
  localparam int QB = $clog2(QW);
  localparam logic [QW:0] Q_POS_LIM = {2'b00, {(QW-1){1'b1}}};
  localparam logic [QW:0] Q_NEG_LIM = {2'b01, {(QW-1){1'b0}}};

  logic          run;
  logic          fin;
  logic [QB-1:0] cnt;
  logic          neg;
  logic          ovf;
  logic [DW-1:0] rem;
  logic [QW-1:0] feed;
  logic [QW-1:0] q;
  logic [DW-1:0] den_r;

  logic [DW-1:0] mag;
  logic [DW:0]   r2;
  logic [DW:0]   den_x;
  logic [DW:0]   diff;
  logic          ge;
  logic          round_up;
  logic [QW:0]   q_rnd;
  logic [QW:0]   lim;
  logic [QW:0]   q_sat;
  logic [QW:0]   q_neg;

  assign mag      = num[DW-1] ? (DW'(0) - num) : num;
  assign den_x    = {1'b0, den_r};
  assign r2       = {rem, feed[QW-1]};
  assign diff     = r2 - den_x;
  assign ge       = (r2 >= den_x);
  assign round_up = ({rem, 1'b0} >= den_x);
  assign q_rnd    = {1'b0, q} + (QW+1)'(round_up);
  assign lim      = neg ? Q_NEG_LIM : Q_POS_LIM;
  // quotient of 2^32 or more shows up as the integer part already >= den
  assign q_sat    = (ovf || (q_rnd > lim)) ? lim : q_rnd;
  assign q_neg    = (QW+1)'(0) - q_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + QB'(1);
        if (cnt == QB'(QW - 1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      neg   <= num[DW-1];
      ovf   <= (DW'(mag[DW-1:FW]) >= den);
      rem   <= DW'(mag[DW-1:FW]);
      feed  <= {mag[FW-1:0], {(QW-FW){1'b0}}};
      den_r <= den;
    end else if (run) begin
      rem  <= ge ? diff[DW-1:0] : r2[DW-1:0];
      q    <= {q[QW-2:0], ge};
      feed <= feed << 1;
    end else if (fin) begin
      quo <= neg ? q_neg[QW-1:0] : q_sat[QW-1:0];
    end
  end

endmodule

// ===== src/lslf_datapath.sv =====
// Datapath: point capture, running sums, determinant products and the four
// quotients, plus the result registers. Depends on lslf_pkg, lslf_mul, lslf_div.
module lslf_datapath #(
  parameter int MAX_POINTS  = lslf_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = lslf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [lslf_pkg::X_W-1:0]            point_index,
  input  logic signed [lslf_pkg::Y_IN_W-1:0]  sample_value,
  input  logic                                final_point,
  input  lslf_pkg::cmd_t                      cmd,
  output lslf_pkg::stat_t                     stat,
  output logic signed [lslf_pkg::Q_W-1:0]     slope_q16,
  output logic signed [lslf_pkg::Q_W-1:0]     intercept_q16,
  output logic signed [lslf_pkg::Q_W-1:0]     fit_at_first,
  output logic signed [lslf_pkg::Q_W-1:0]     fit_at_count,
  output logic [lslf_pkg::N_OUT_W-1:0]        points_used,
  output logic                                degenerate,
  output logic                                done
);

  localparam int X_W    = lslf_pkg::X_W;
  localparam int DW     = lslf_pkg::DET_W;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int YB     = (SAMPLE_BITS < lslf_pkg::Y_IN_W) ? SAMPLE_BITS : lslf_pkg::Y_IN_W;
  localparam int Y_W    = YB + 1;
  localparam int XX_W   = 2 * X_W;
  localparam int XY_W   = X_W + 1 + Y_W;
  localparam int SX_W   = X_W + CNT_W;
  localparam int SXX_W  = XX_W + CNT_W;
  localparam int SY_W   = Y_W + CNT_W;
  localparam int SXY_W  = XY_W + CNT_W;
  localparam int OPR_N  = CNT_W + 1;
  localparam int OPR_SX = SX_W + 1;
  localparam int OPR_NX = (OPR_N > OPR_SX) ? OPR_N : OPR_SX;
  localparam int OP_RAW = (OPR_NX > SY_W) ? OPR_NX : SY_W;
  localparam int ND     = (OP_RAW + lslf_pkg::DIGIT_W - 1) / lslf_pkg::DIGIT_W;
  localparam int OP_W   = ND * lslf_pkg::DIGIT_W;
  localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_POINTS);

  // latched item
  logic [X_W-1:0]         x_r;
  logic signed [Y_W-1:0]  y_r;
  logic                   fin_r;

  // running sums
  logic [CNT_W-1:0]        cnt;
  logic [SX_W-1:0]         sx;
  logic [SXX_W-1:0]        sxx;
  logic signed [SY_W-1:0]  sy;
  logic signed [SXY_W-1:0] sxy;

  // solve registers, all mod 2^64
  logic [DW-1:0] t0;
  logic [DW-1:0] det;
  logic [DW-1:0] det_a;
  logic [DW-1:0] det_b;
  logic [DW-1:0] num_ab;
  logic [DW-1:0] num_n;

  logic                   y_sign;
  logic signed [Y_W-1:0]  y_in;
  logic [XX_W-1:0]        xx;
  logic signed [XY_W-1:0] xy;
  logic [DW-1:0]          mul_a;
  logic [OP_W-1:0]        mul_b;
  logic [DW-1:0]          mul_p;
  logic                   mul_done;
  logic [DW-1:0]          div_num;
  logic [lslf_pkg::Q_W-1:0] div_q;
  logic                   div_done;
  logic                   det_zero;

  // above 16 sample bits the port value is taken as non-negative
  assign y_sign = (SAMPLE_BITS <= lslf_pkg::Y_IN_W) ? sample_value[YB-1] : 1'b0;
  assign y_in   = $signed({y_sign, sample_value[YB-1:0]});

  assign xx = XX_W'(x_r) * XX_W'(x_r);
  assign xy = XY_W'($signed({1'b0, x_r})) * XY_W'(y_r);

  assign det_zero = (det == '0);
  assign stat     = '{final_pt: fin_r, det_zero: det_zero,
                      mul_done: mul_done, div_done: div_done};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      x_r   <= point_index;
      y_r   <= y_in;
      fin_r <= final_point;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      cnt <= '0;
      sx  <= '0;
      sxx <= '0;
      sy  <= '0;
      sxy <= '0;
    end else if (cmd.accum && (cnt < CNT_LIMIT)) begin
      cnt <= cnt + CNT_W'(1);
      sx  <= sx + SX_W'(x_r);
      sxx <= sxx + SXX_W'(xx);
      sy  <= sy + SY_W'(y_r);
      sxy <= sxy + SXY_W'(xy);
    end
  end

  always_comb begin
    mul_a = DW'(sxx);
    mul_b = OP_W'(cnt);
    case (cmd.mstep)
      lslf_pkg::MS_SXX_N: begin
        mul_a = DW'(sxx);
        mul_b = OP_W'(cnt);
      end
      lslf_pkg::MS_SX_SX: begin
        mul_a = DW'(sx);
        mul_b = OP_W'(sx);
      end
      lslf_pkg::MS_SXY_N: begin
        mul_a = DW'(sxy);
        mul_b = OP_W'(cnt);
      end
      lslf_pkg::MS_SY_SX: begin
        mul_a = DW'(sy);
        mul_b = OP_W'(sx);
      end
      lslf_pkg::MS_SXX_SY: begin
        mul_a = DW'(sxx);
        mul_b = OP_W'(sy);
      end
      lslf_pkg::MS_SX_SXY: begin
        mul_a = DW'(sxy);
        mul_b = OP_W'(sx);
      end
      lslf_pkg::MS_A_N: begin
        mul_a = det_a;
        mul_b = OP_W'(cnt);
      end
      default: begin
        mul_a = DW'(sxx);
        mul_b = OP_W'(cnt);
      end
    endcase
  end

  lslf_mul #(
    .ND (ND)
  ) u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.mul_go),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_p),
    .done (mul_done)
  );

  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (cmd.mstep)
        lslf_pkg::MS_SXX_N,
        lslf_pkg::MS_SXY_N,
        lslf_pkg::MS_SXX_SY: t0 <= mul_p;
        lslf_pkg::MS_SX_SX:  det <= t0 - mul_p;
        lslf_pkg::MS_SY_SX:  det_a <= t0 - mul_p;
        lslf_pkg::MS_SX_SXY: det_b <= t0 - mul_p;
        lslf_pkg::MS_A_N: begin
          num_n  <= mul_p + det_b;
          num_ab <= det_a + det_b;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cmd.dstep)
      lslf_pkg::DS_SLOPE:     div_num = det_a;
      lslf_pkg::DS_INTERCEPT: div_num = det_b;
      lslf_pkg::DS_FIRST:     div_num = num_ab;
      lslf_pkg::DS_COUNT:     div_num = num_n;
      default:                div_num = det_a;
    endcase
  end

  lslf_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.div_go),
    .num  (div_num),
    .den  (det),
    .quo  (div_q),
    .done (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      points_used <= lslf_pkg::N_OUT_W'(cnt);
      degenerate  <= det_zero;
      if (det_zero) begin
        slope_q16     <= '0;
        intercept_q16 <= '0;
        fit_at_first  <= '0;
        fit_at_count  <= '0;
      end
    end else if (div_done) begin
      case (cmd.dstep)
        lslf_pkg::DS_SLOPE:     slope_q16     <= div_q;
        lslf_pkg::DS_INTERCEPT: intercept_q16 <= div_q;
        lslf_pkg::DS_FIRST:     fit_at_first  <= div_q;
        lslf_pkg::DS_COUNT:     fit_at_count  <= div_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
  end

endmodule

// ===== src/lslf_ctrl.sv =====
// Controller: sequences accumulate, the seven products and the four divisions.
// Talks to the datapath only through lslf_pkg::cmd_t and lslf_pkg::stat_t.
module lslf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  output lslf_pkg::cmd_t  cmd,
  input  lslf_pkg::stat_t stat
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_ACC      = 7'b0000010,
    S_MUL_GO   = 7'b0000100,
    S_MUL_WAIT = 7'b0001000,
    S_DIV_GO   = 7'b0010000,
    S_DIV_WAIT = 7'b0100000,
    S_EMIT     = 7'b1000000
  } state_t;

  state_t           state, state_next;
  lslf_pkg::mstep_t mstep, mstep_next;
  lslf_pkg::dstep_t dstep, dstep_next;

  always_comb begin
    state_next = state;
    mstep_next = mstep;
    dstep_next = dstep;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_ACC;
      end
      S_ACC: begin
        if (stat.final_pt) begin
          mstep_next = lslf_pkg::MS_SXX_N;
          state_next = S_MUL_GO;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MUL_GO: state_next = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (stat.mul_done) begin
          if (mstep == lslf_pkg::MS_A_N) begin
            if (stat.det_zero) begin
              state_next = S_EMIT;
            end else begin
              dstep_next = lslf_pkg::DS_SLOPE;
              state_next = S_DIV_GO;
            end
          end else begin
            mstep_next = lslf_pkg::mstep_t'(mstep + 3'd1);
            state_next = S_MUL_GO;
          end
        end
      end
      S_DIV_GO: state_next = S_DIV_WAIT;
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          if (dstep == lslf_pkg::DS_COUNT) begin
            state_next = S_EMIT;
          end else begin
            dstep_next = lslf_pkg::dstep_t'(dstep + 2'd1);
            state_next = S_DIV_GO;
          end
        end
      end
      S_EMIT:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mstep <= lslf_pkg::MS_SXX_N;
      dstep <= lslf_pkg::DS_SLOPE;
    end else begin
      state <= state_next;
      mstep <= mstep_next;
      dstep <= dstep_next;
    end
  end

  assign busy = (state != S_IDLE);

  assign cmd = '{capture: (state == S_IDLE) && start,
                 accum:   (state == S_ACC),
                 mul_go:  (state == S_MUL_GO),
                 div_go:  (state == S_DIV_GO),
                 emit:    (state == S_EMIT),
                 mstep:   mstep,
                 dstep:   dstep};

endmodule

// ===== src/least_squares_line_fit.sv =====
// Least-squares line fit: streams (x, y) points, solves slope and intercept on
// the last point. Top level; depends on lslf_pkg, lslf_ctrl, lslf_datapath.
//
// A point is taken when start is high and busy is low; an ordinary point keeps
// busy high for one cycle, so a new point is taken only once busy is low again.
// A point with final_point set also runs the solve: seven products on a shared
// multiplier that takes one 8-bit digit a cycle (ND = 4 at default sizes),
// then four divisions on a shared one-bit-a-cycle divider; the divisions are
// skipped when the determinant is zero. The result is shown for exactly one
// cycle with done high, in the first cycle busy is low; the receiver must take
// it then, it cannot hold the block off. The sums are cleared with the result,
// and points beyond MAX_POINTS are not accumulated.
module least_squares_line_fit #(
  parameter int MAX_POINTS  = lslf_pkg::MAX_POINTS_DEF,
  parameter int SAMPLE_BITS = lslf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [lslf_pkg::X_W-1:0]            point_index,
  input  logic signed [lslf_pkg::Y_IN_W-1:0]  sample_value,
  input  logic                                final_point,
  output logic                                done,
  output logic signed [lslf_pkg::Q_W-1:0]     slope_q16,
  output logic signed [lslf_pkg::Q_W-1:0]     intercept_q16,
  output logic signed [lslf_pkg::Q_W-1:0]     fit_at_first,
  output logic signed [lslf_pkg::Q_W-1:0]     fit_at_count,
  output logic [lslf_pkg::N_OUT_W-1:0]        points_used,
  output logic                                degenerate
);

  lslf_pkg::cmd_t  cmd;
  lslf_pkg::stat_t stat;

  lslf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  lslf_datapath #(
    .MAX_POINTS  (MAX_POINTS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .point_index   (point_index),
    .sample_value  (sample_value),
    .final_point   (final_point),
    .cmd           (cmd),
    .stat          (stat),
    .slope_q16     (slope_q16),
    .intercept_q16 (intercept_q16),
    .fit_at_first  (fit_at_first),
    .fit_at_count  (fit_at_count),
    .points_used   (points_used),
    .degenerate    (degenerate),
    .done          (done)
  );

endmodule
